### sv/tcf_pkg.sv
// Shared constants and the CORDIC arctangent table for the tilt filter.
// No dependencies; imported by tilt_complementary_filter.
package tcf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = 5;
  localparam int SQRT_STEPS   = 16;
  localparam int RECIP_STEPS  = 4;
  localparam int ANGLE_LIMIT  = 5898240;

  // Gyro increment: round(m*512/131000) = floor((64*m + 8187) / 16375), taken as
  // (n * ceil(2^61/16375)) >> 61 with the constant split into four shifted terms.
  localparam logic [15:0] GYRO_RND    = 16'd8187;
  localparam int          GYRO_QSHIFT = 61;
  localparam logic [14:0] GYRO_K0 = 15'd1;
  localparam logic [14:0] GYRO_K1 = 15'd9;
  localparam logic [14:0] GYRO_K2 = 15'd81;
  localparam logic [14:0] GYRO_K3 = 15'd23341;
  localparam int          GYRO_S0 = 47;
  localparam int          GYRO_S1 = 33;
  localparam int          GYRO_S2 = 19;
  localparam int          GYRO_S3 = 0;

  // Temperature: floor((m + 42) / 85) = (n * ceil(2^32/85)) >> 32, 0x03030304.
  localparam logic [16:0] TEMP_HALF   = 17'd42;
  localparam int          TEMP_QSHIFT = 32;
  localparam logic [14:0] TEMP_K0 = 15'd3;
  localparam logic [14:0] TEMP_K1 = 15'd3;
  localparam logic [14:0] TEMP_K2 = 15'd3;
  localparam logic [14:0] TEMP_K3 = 15'd4;
  localparam int          TEMP_S0 = 24;
  localparam int          TEMP_S1 = 16;
  localparam int          TEMP_S2 = 8;
  localparam int          TEMP_S3 = 0;

  localparam logic signed [16:0] TEMP_BIAS = 17'sd12412;

  localparam logic [16:0] GW_RESET = 17'd64225;
  localparam logic [16:0] AW_RESET = 17'd1311;

  localparam logic [2:0] REG_OFF_X = 3'd0;
  localparam logic [2:0] REG_OFF_Y = 3'd1;
  localparam logic [2:0] REG_OFF_Z = 3'd2;
  localparam logic [2:0] REG_GW    = 3'd3;
  localparam logic [2:0] REG_AW    = 3'd4;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [23:0] atan_entry(input logic [ITER_W-1:0] i);
    logic signed [23:0] v;
    case (i)
      5'd0:  v = 24'sd2949120;
      5'd1:  v = 24'sd1740967;
      5'd2:  v = 24'sd919879;
      5'd3:  v = 24'sd466945;
      5'd4:  v = 24'sd234379;
      5'd5:  v = 24'sd117304;
      5'd6:  v = 24'sd58666;
      5'd7:  v = 24'sd29335;
      5'd8:  v = 24'sd14668;
      5'd9:  v = 24'sd7334;
      5'd10: v = 24'sd3667;
      5'd11: v = 24'sd1833;
      5'd12: v = 24'sd917;
      5'd13: v = 24'sd458;
      5'd14: v = 24'sd229;
      5'd15: v = 24'sd115;
      5'd16: v = 24'sd57;
      5'd17: v = 24'sd29;
      5'd18: v = 24'sd14;
      5'd19: v = 24'sd7;
      5'd20: v = 24'sd4;
      5'd21: v = 24'sd2;
      5'd22: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

### sv/tilt_complementary_filter.sv
// Tilt estimator: CORDIC accelerometer tilt, gyro integration, complementary blend.
// Depends on tcf_pkg for constants and the arctangent table.

// A request is taken in the idle state. Per tilt axis the sequencer then runs
// 16 square-root steps and CORDIC_STEPS rotations; per gyro axis and for
// temperature, 4 reciprocal-multiply accumulate steps; then it blends each tilt
// axis and posts the result in its final step. The square-root and CORDIC
// passes take most of a request. in_ready is high only while the sequencer is
// idle; a finished result sits in the output register and the next request is
// taken while it waits.
module tilt_complementary_filter
  import tcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic signed [15:0] raw_temperature,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] fused_angle_x,
  output logic signed [31:0] fused_angle_y,
  output logic signed [23:0] accel_angle_x,
  output logic signed [23:0] accel_angle_y,
  output logic signed [31:0] gyro_angle_x,
  output logic signed [31:0] gyro_angle_y,
  output logic signed [31:0] gyro_angle_z,
  output logic signed [16:0] temperature
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQ_MUL  = 4'd1;
  localparam logic [3:0] ST_SQ_ADD  = 4'd2;
  localparam logic [3:0] ST_SQ_RUN  = 4'd3;
  localparam logic [3:0] ST_CR_INIT = 4'd4;
  localparam logic [3:0] ST_CR_RUN  = 4'd5;
  localparam logic [3:0] ST_CR_DONE = 4'd6;
  localparam logic [3:0] ST_DV_MUL  = 4'd7;
  localparam logic [3:0] ST_DV_LOAD = 4'd8;
  localparam logic [3:0] ST_DV_RUN  = 4'd9;
  localparam logic [3:0] ST_DV_DONE = 4'd10;
  localparam logic [3:0] ST_BL_MUL  = 4'd11;
  localparam logic [3:0] ST_BL_SUM  = 4'd12;
  localparam logic [3:0] ST_FIN     = 4'd13;

  logic [3:0] state;
  logic [1:0] pass;
  logic [5:0] cnt;

  logic signed [23:0] off_x, off_y, off_z;
  logic [16:0]        gw, aw;

  logic signed [15:0] ax, ay, az, rx, ry, rz, rt;
  logic [15:0]        ms;

  logic signed [31:0] fused_x, fused_y, gint_x, gint_y, gint_z;

  logic [30:0] pp, qq;
  logic [31:0] sq_n, sq_res, sq_bit;
  logic signed [27:0] cx, cy;
  logic signed [25:0] cz;
  logic signed [23:0] ang_x, ang_y;

  logic signed [42:0] prod;
  logic               neg;
  logic [45:0]        dv_num;
  logic [95:0]        dv_acc;
  logic signed [35:0] dx, dy, dz;
  logic signed [16:0] temp_val;

  logic signed [53:0] m1;
  logic signed [41:0] m2;

  // operand selection and datapath terms
  logic signed [15:0] num, p, q, raw;
  logic signed [23:0] off;
  logic signed [25:0] diff;
  logic signed [16:0] tb;
  logic [32:0]        trial;
  logic signed [27:0] xs, ys;
  logic signed [25:0] at;
  logic [42:0]        mag;
  logic [14:0]        rk;
  logic [60:0]        kprod;
  logic [95:0]        term;
  logic [34:0]        quo;
  logic signed [35:0] qs;
  logic signed [25:0] zsat;
  logic signed [23:0] ang;
  logic signed [31:0] prev;
  logic signed [35:0] dsel, g;
  logic signed [23:0] acc;
  logic signed [54:0] s;
  logic signed [38:0] r;
  logic signed [31:0] rsat;

  always_comb begin
    num = pass[0] ? ax : ay;
    p   = az;
    q   = pass[0] ? ay : ax;
    case (pass)
      2'd0:    begin raw = rx; off = off_x; end
      2'd1:    begin raw = ry; off = off_y; end
      default: begin raw = rz; off = off_z; end
    endcase
    diff  = $signed({{2{raw[15]}}, raw, 8'b0}) - $signed({{2{off[23]}}, off});
    tb    = $signed({rt[15], rt}) + TEMP_BIAS;
    trial = {1'b0, sq_res} + {1'b0, sq_bit};
    xs    = cx >>> cnt[ITER_W-1:0];
    ys    = cy >>> cnt[ITER_W-1:0];
    at    = 26'(atan_entry(cnt[ITER_W-1:0]));
    mag   = prod[42] ? 43'(-prod) : prod;
    // one shifted partial product of the reciprocal per step
    case (cnt[1:0])
      2'd0:    rk = (pass == 2'd3) ? TEMP_K0 : GYRO_K0;
      2'd1:    rk = (pass == 2'd3) ? TEMP_K1 : GYRO_K1;
      2'd2:    rk = (pass == 2'd3) ? TEMP_K2 : GYRO_K2;
      default: rk = (pass == 2'd3) ? TEMP_K3 : GYRO_K3;
    endcase
    kprod = 61'(dv_num * rk);
    case (cnt[1:0])
      2'd0:    term = (pass == 2'd3) ? 96'(kprod) << TEMP_S0 : 96'(kprod) << GYRO_S0;
      2'd1:    term = (pass == 2'd3) ? 96'(kprod) << TEMP_S1 : 96'(kprod) << GYRO_S1;
      2'd2:    term = (pass == 2'd3) ? 96'(kprod) << TEMP_S2 : 96'(kprod) << GYRO_S2;
      default: term = (pass == 2'd3) ? 96'(kprod) << TEMP_S3 : 96'(kprod) << GYRO_S3;
    endcase
    quo = (pass == 2'd3) ? dv_acc[TEMP_QSHIFT +: 35] : dv_acc[GYRO_QSHIFT +: 35];
    qs  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (cz > ANGLE_LIMIT) zsat = 26'(ANGLE_LIMIT);
    else if (cz < -ANGLE_LIMIT) zsat = -26'(ANGLE_LIMIT);
    else zsat = cz;
    ang  = (num == 16'sd0) ? 24'sd0 : zsat[23:0];
    prev = pass[0] ? fused_y : fused_x;
    dsel = pass[0] ? dy : dx;
    acc  = pass[0] ? ang_y : ang_x;
    g    = $signed({{4{prev[31]}}, prev}) + dsel;
    s    = $signed({m1[53], m1}) + $signed({{13{m2[41]}}, m2}) + 55'sd32768;
    r    = s[54:16];
    if (r > 39'sd2147483647) rsat = 32'sh7FFFFFFF;
    else if (r < -39'sd2147483648) rsat = 32'sh80000000;
    else rsat = r[31:0];
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      gw    <= GW_RESET;
      aw    <= AW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OFF_X: off_x <= cfg_data;
        REG_OFF_Y: off_y <= cfg_data;
        REG_OFF_Z: off_z <= cfg_data;
        REG_GW:    gw    <= cfg_data[16:0];
        REG_AW:    aw    <= cfg_data[16:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      fused_x   <= '0;
      fused_y   <= '0;
      gint_x    <= '0;
      gint_y    <= '0;
      gint_z    <= '0;
    end else begin
      // the final step posts its own result in place of the one taken
      if (out_valid && out_ready && state != ST_FIN) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ax <= accel_x; ay <= accel_y; az <= accel_z;
            rx <= rate_x;  ry <= rate_y;  rz <= rate_z;
            rt <= raw_temperature;
            ms <= elapsed_ms;
            pass  <= '0;
            state <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: begin
          pp    <= 31'(p * p);
          qq    <= 31'(q * q);
          state <= ST_SQ_ADD;
        end
        ST_SQ_ADD: begin
          sq_n   <= {1'b0, pp} + {1'b0, qq};
          sq_res <= '0;
          sq_bit <= 32'h4000_0000;
          cnt    <= '0;
          state  <= ST_SQ_RUN;
        end
        ST_SQ_RUN: begin
          if ({1'b0, sq_n} >= trial) begin
            sq_n   <= sq_n - trial[31:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(SQRT_STEPS - 1)) state <= ST_CR_INIT;
        end
        ST_CR_INIT: begin
          cx    <= $signed({4'b0, sq_res[15:0], 8'b0});
          cy    <= $signed({{4{num[15]}}, num, 8'b0});
          cz    <= '0;
          cnt   <= '0;
          state <= ST_CR_RUN;
        end
        ST_CR_RUN: begin
          if (!cy[27]) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
          end else begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CORDIC_STEPS - 1)) state <= ST_CR_DONE;
        end
        ST_CR_DONE: begin
          if (pass[0]) begin
            ang_y <= -ang;
            pass  <= '0;
            state <= ST_DV_MUL;
          end else begin
            ang_x <= ang;
            pass  <= 2'd1;
            state <= ST_SQ_MUL;
          end
        end
        ST_DV_MUL: begin
          if (pass == 2'd3) prod <= $signed({{20{tb[16]}}, tb, 6'b0});
          else prod <= diff * $signed({1'b0, ms});
          state <= ST_DV_LOAD;
        end
        ST_DV_LOAD: begin
          neg <= prod[42];
          if (pass == 2'd3) dv_num <= 46'(mag) + 46'(TEMP_HALF);
          else dv_num <= {mag[39:0], 6'b0} + 46'(GYRO_RND);
          dv_acc <= '0;
          cnt    <= '0;
          state  <= ST_DV_RUN;
        end
        ST_DV_RUN: begin
          dv_acc <= dv_acc + term;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(RECIP_STEPS - 1)) state <= ST_DV_DONE;
        end
        ST_DV_DONE: begin
          case (pass)
            2'd0:    dx <= qs;
            2'd1:    dy <= qs;
            2'd2:    dz <= qs;
            default: temp_val <= qs[16:0];
          endcase
          if (pass == 2'd3) begin
            pass  <= '0;
            state <= ST_BL_MUL;
          end else begin
            pass  <= pass + 2'd1;
            state <= ST_DV_MUL;
          end
        end
        ST_BL_MUL: begin
          m1    <= g * $signed({1'b0, gw});
          m2    <= acc * $signed({1'b0, aw});
          state <= ST_BL_SUM;
        end
        ST_BL_SUM: begin
          if (pass[0]) begin
            fused_y <= rsat;
            pass    <= '0;
            state   <= ST_FIN;
          end else begin
            fused_x <= rsat;
            pass    <= 2'd1;
            state   <= ST_BL_MUL;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            gint_x        <= gint_x + dx[31:0];
            gint_y        <= gint_y + dy[31:0];
            gint_z        <= gint_z + dz[31:0];
            gyro_angle_x  <= gint_x + dx[31:0];
            gyro_angle_y  <= gint_y + dy[31:0];
            gyro_angle_z  <= gint_z + dz[31:0];
            fused_angle_x <= fused_x;
            fused_angle_y <= fused_y;
            accel_angle_x <= ang_x;
            accel_angle_y <= ang_y;
            temperature   <= temp_val;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer took a second request");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result posted outside final step");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accel_angle_x <= ANGLE_LIMIT && accel_angle_x >= -ANGLE_LIMIT
               && accel_angle_y <= ANGLE_LIMIT && accel_angle_y >= -ANGLE_LIMIT)
    else $error("tilt angle beyond 90 degrees");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DV_RUN |-> cnt < 6'(RECIP_STEPS))
    else $error("divider step count overran");

endmodule
